### rtl/deq_pkg.sv
package deq_pkg;

	// Store geometry.
	localparam int DEPTH = 16;
	localparam int WIDTH = 32;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	// Width of a head plus offset sum, wide enough for a 4-bit position too.
	localparam int SW = ((AW > 4) ? AW : 4) + 1;

	typedef logic [WIDTH-1:0] word_t;
	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_READ       = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Physical slot of a logical offset from the head. The offset stays below
	// twice the depth wherever the result is used, so one subtract suffices.
	function automatic addr_t ring_addr(addr_t head, logic [SW-1:0] offs);
		logic [SW-1:0] sum;
		sum = SW'(head) + offs;
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return AW'(sum);
	endfunction

endpackage

### rtl/deq_ram.sv
module deq_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/indexed_double_ended_queue_unit.sv
// Double-ended queue of 32-bit words with indexed reads, held in a 16-entry
// ring memory with a head pointer. Each input beat pushes at the front, pushes
// at the back, or reads the element at a position counted from the front; each
// yields one output beat with the read word, the front and back words, the
// count, an empty flag and a status (push into a full queue is dropped, a read
// past the count is out of range). A beat is accepted every cycle while the
// output side takes results: an item passes through the stage that waits on
// the synchronous memory read, then sits in the output register. The memory's
// single read port serves indexed reads; front and back words are kept in
// registers.
module indexed_double_ended_queue_unit
	import deq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [31:0] front_word,
	output logic [31:0] back_word,
	output logic [4:0]  count,
	output logic        is_empty,
	output logic [1:0]  status
);

	// Architectural state.
	addr_t head_q;
	cnt_t  cnt_q;
	word_t front_q;
	word_t back_q;

	// Stage waiting on the memory read.
	logic    valid_s1;
	word_t   front_s1;
	word_t   back_s1;
	cnt_t    cnt_s1;
	status_t status_s1;
	logic    hit_s1;

	// Output register.
	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic [31:0] front_q_out_q;
	logic [31:0] back_q_out_q;
	logic [4:0]  count_q;
	logic        is_empty_q;
	logic [1:0]  status_q;

	logic    accept;
	logic    s1_move;
	logic    out_free;
	op_t     op_in;
	word_t   val_in;
	logic    full;
	logic    do_push;
	logic    mem_we;
	addr_t   mem_waddr;
	logic    mem_re;
	addr_t   mem_raddr;
	word_t   mem_rdata;
	addr_t   head_nxt;
	cnt_t    cnt_nxt;
	word_t   front_nxt;
	word_t   back_nxt;
	status_t status_nxt;
	logic    hit_nxt;

	// Handshake between input, memory stage and output register.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;

	assign op_in  = op_t'(op);
	assign val_in = WIDTH'(value);
	assign full   = (cnt_q >= CW'(DEPTH));

	// Next state, memory access and status for the incoming beat.
	always_comb begin
		do_push    = 1'b0;
		mem_waddr  = head_q;
		head_nxt   = head_q;
		cnt_nxt    = cnt_q;
		front_nxt  = front_q;
		back_nxt   = back_q;
		status_nxt = ST_OK;
		hit_nxt    = 1'b0;
		unique case (op_in)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					do_push   = 1'b1;
					head_nxt  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
					mem_waddr = head_nxt;
					cnt_nxt   = cnt_q + CW'(1);
					front_nxt = val_in;
					if (cnt_q == '0) begin
						back_nxt = val_in;
					end
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					do_push   = 1'b1;
					mem_waddr = ring_addr(head_q, SW'(cnt_q));
					cnt_nxt   = cnt_q + CW'(1);
					back_nxt  = val_in;
					if (cnt_q == '0) begin
						front_nxt = val_in;
					end
				end
			end
			OP_READ: begin
				if (SW'(position) >= SW'(cnt_q)) begin
					status_nxt = ST_RANGE;
				end else begin
					hit_nxt = 1'b1;
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign mem_we    = accept && do_push;
	assign mem_re    = accept && (op_in == OP_READ);
	assign mem_raddr = ring_addr(head_q, SW'(position));

	deq_ram #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(val_in),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_nxt;
				cnt_q  <= cnt_nxt;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Front and back words, plus the payload of the memory stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			front_q   <= front_nxt;
			back_q    <= back_nxt;
			front_s1  <= front_nxt;
			back_s1   <= back_nxt;
			cnt_s1    <= cnt_nxt;
			status_s1 <= status_nxt;
			hit_s1    <= hit_nxt;
		end
	end

	// Output register; words read as zero when the queue is empty.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_data_q   <= hit_s1 ? 32'(mem_rdata) : '0;
			front_q_out_q <= (cnt_s1 == '0) ? '0 : 32'(front_s1);
			back_q_out_q  <= (cnt_s1 == '0) ? '0 : 32'(back_s1);
			count_q       <= 5'(cnt_s1);
			is_empty_q    <= (cnt_s1 == '0);
			status_q      <= status_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign front_word = front_q_out_q;
	assign back_word  = back_q_out_q;
	assign count      = count_q;
	assign is_empty   = is_empty_q;
	assign status     = status_q;

endmodule

### tb/sv/indexed_double_ended_queue_unit_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the queue, predicts each output beat from the
// accepted input beats and compares the two field by field.
module indexed_double_ended_queue_unit_checker
	import deq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] read_data,
	input  logic [31:0] front_word,
	input  logic [31:0] back_word,
	input  logic [4:0]  count,
	input  logic        is_empty,
	input  logic [1:0]  status,
	output int          fails,
	output int          outstanding
);

	typedef struct packed {
		word_t   rd;
		word_t   front;
		word_t   back;
		cnt_t    fill;
		logic    empty;
		status_t st;
	} deq_result_t;

	// Shadow copy of the ring and its pointers.
	word_t ring [DEPTH];
	int head;
	int fill;

	// Newest prediction sits at the front, the oldest is taken from the back.
	deq_result_t pending_results [$];
	int errors;

	// Applies one input beat to the shadow queue and returns the beat it should produce.
	function automatic deq_result_t apply_beat(input op_t code, input word_t word,
			input logic [3:0] pos);
		deq_result_t r;
		r = '0;
		r.st = ST_OK;
		case (code)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			if (fill >= DEPTH) begin
				r.st = ST_FULL;
			end else if (code == OP_PUSH_FRONT) begin
				head = (head + DEPTH - 1) % DEPTH;
				ring[head] = word;
				fill++;
			end else begin
				ring[(head + fill) % DEPTH] = word;
				fill++;
			end
		end
		OP_READ: begin
			if (int'(pos) >= fill) begin
				r.st = ST_RANGE;
			end else begin
				r.rd = ring[(head + int'(pos)) % DEPTH];
			end
		end
		default: begin
		end
		endcase
		// Front and back read as zero while the queue is empty.
		if (fill != 0) begin
			r.front = ring[head];
			r.back = ring[(head + fill - 1) % DEPTH];
		end
		r.fill = cnt_t'(fill);
		r.empty = (fill == 0);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch on %s: expected %h, got %h", field, want, got);
			end
		end
	endtask

	// Score output beats first, then record the prediction for a new input beat.
	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		if (!arst_n) begin
			foreach (ring[i]) begin
				ring[i] = '0;
			end
			head = 0;
			fill = 0;
			pending_results.delete();
			errors = 0;
			fails <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("output beat with no prediction waiting");
					end
				end else begin
					want = pending_results.pop_back();
					check_field("read_data", want.rd, read_data);
					check_field("front_word", want.front, front_word);
					check_field("back_word", want.back, back_word);
					check_field("count", 32'(want.fill), 32'(count));
					check_field("is_empty", 32'(want.empty), 32'(is_empty));
					check_field("status", 32'(want.st), 32'(status));
				end
			end
			if (in_valid && !in_stall) begin
				pending_results.push_front(apply_beat(op_t'(op), value, position));
			end
			outstanding <= pending_results.size();
			fails <= errors;
		end
	end

endmodule

### tb/sv/indexed_double_ended_queue_unit_tb.sv
`timescale 1ns / 100ps

module indexed_double_ended_queue_unit_tb;
	import deq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 1800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [1:0]  op = OP_NONE;
	logic [31:0] value = '0;
	logic [3:0]  position = '0;
	logic        out_stall = 1'b0;
	logic        quiet = 1'b0;
	int          cycles = 0;

	logic        in_stall;
	logic        out_valid;
	logic [31:0] read_data;
	logic [31:0] front_word;
	logic [31:0] back_word;
	logic [4:0]  count;
	logic        is_empty;
	logic [1:0]  status;
	int          fails;
	int          outstanding;

	indexed_double_ended_queue_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.value      (value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.front_word (front_word),
		.back_word  (back_word),
		.count      (count),
		.is_empty   (is_empty),
		.status     (status)
	);

	indexed_double_ended_queue_unit_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.front_word  (front_word),
		.back_word   (back_word),
		.count       (count),
		.is_empty    (is_empty),
		.status      (status),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The result side stalls now and then, except during the quiet stretch.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 9);
	end

	// Presents one beat, with an optional idle gap first, and holds it until taken.
	task automatic send_beat(input op_t code, input word_t word, input logic [3:0] pos);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		value <= word;
		position <= pos;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Holds off the input until every predicted beat has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	// Words lean toward all zeros and all ones now and then.
	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
		0: begin
			return '0;
		end
		1: begin
			return '1;
		end
		default: begin
			return $urandom();
		end
		endcase
	endfunction

	initial begin
		int roll;
		op_t code;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: reads are out of range and the unused op does nothing.
		send_beat(OP_READ, '0, 4'd0);
		send_beat(OP_READ, '0, 4'd15);
		send_beat(OP_NONE, 32'hFFFF_FFFF, 4'd15);
		// Partial fill from both ends, wrapping the head below slot zero.
		send_beat(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
		send_beat(OP_READ, '0, 4'd0);
		send_beat(OP_READ, '0, 4'd1);
		send_beat(OP_PUSH_FRONT, 32'h0000_0000, 4'd0);
		send_beat(OP_PUSH_FRONT, 32'h8000_0000, 4'd0);
		send_beat(OP_PUSH_BACK, 32'h0000_0001, 4'd0);
		send_beat(OP_PUSH_BACK, 32'h7FFF_FFFF, 4'd0);
		send_beat(OP_READ, '0, 4'd4);
		send_beat(OP_READ, '0, 4'd5);
		send_beat(OP_NONE, '0, 4'd0);
		send_beat(OP_PUSH_FRONT, 32'hA5A5_A5A5, 4'd0);
		send_beat(OP_READ, '0, 4'd15);
		send_beat(OP_READ, '0, 4'd2);
		drain_results();

		// Random mix: the queue fills early on, after which pushes are dropped.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			quiet <= (i >= 700 && i < 1000);
			if (i == 1200) begin
				drain_results();
			end
			roll = $urandom_range(0, 99);
			if (roll < 18) begin
				code = OP_PUSH_FRONT;
			end else if (roll < 36) begin
				code = OP_PUSH_BACK;
			end else if (roll < 90) begin
				code = OP_READ;
			end else begin
				code = OP_NONE;
			end
			send_beat(code, pick_word(), 4'($urandom_range(0, 15)));
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### indexed_double_ended_queue_unit.f
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/indexed_double_ended_queue_unit.sv
tb/sv/indexed_double_ended_queue_unit_checker.sv
tb/sv/indexed_double_ended_queue_unit_tb.sv
